FILE: rtl/btfc_pkg.sv
// Shared types and constants for the balanced ternary fraction converter.
`timescale 1ns / 1ps

package btfc_pkg;

	typedef logic [3:0] state_t;
	typedef logic [1:0] digit_t;

	// Sequencer states.
	localparam state_t ST_IDLE     = 4'd0;
	localparam state_t ST_DIV      = 4'd1;
	localparam state_t ST_INT_MUL  = 4'd2;
	localparam state_t ST_INT_SUB  = 4'd3;
	localparam state_t ST_FRAC     = 4'd4;
	localparam state_t ST_CARRY_RD = 4'd5;
	localparam state_t ST_CARRY_WR = 4'd6;
	localparam state_t ST_HEAD     = 4'd7;
	localparam state_t ST_EMIT_RD  = 4'd8;
	localparam state_t ST_EMIT_LD  = 4'd9;
	localparam state_t ST_SEND     = 4'd10;

	// Balanced ternary symbol codes on the output.
	localparam digit_t DIGIT_ZERO  = 2'd0;
	localparam digit_t DIGIT_PLUS  = 2'd1;
	localparam digit_t DIGIT_MINUS = 2'd2;

	// floor(x / 3) == (x * RECIP3) >> 33 for every 32-bit x.
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

endpackage

FILE: rtl/balanced_ternary_fraction_converter.sv
// Top level of the balanced ternary fraction converter.
`timescale 1ns / 1ps

// Usage: an input transaction (numerator, denominator) on in_valid/in_ready starts
// one conversion; the result digits leave on out_valid/out_ready, most significant
// first, one transaction per digit, with last set on the final digit.
// in_ready is high only while the converter is idle, so one number is in flight.
// Steps per number: the accepting cycle, restoring division by the denominator,
// per integer digit a reciprocal multiply by three and then the remainder, a
// fraction step per fraction digit, a read and a write per digit for the carry
// pass through the digit memory, setting up the head digit, then a read, a load
// and a send with any receiver stall per digit sent (only the send for a carry or
// lone 0 digit). The single digit memory port pair paces the carry and send
// passes.
// A zero denominator skips the work and sends one 0 digit; a zero
// numerator sends one 0 digit after the division.
// When the receiver stalls, the current digit holds in the output register and the
// sequencer waits. Reset returns to idle with no output pending; digit memory
// content is not cleared, since every entry read is written first.
module balanced_ternary_fraction_converter #(
	parameter int MAX_INT_DIGITS  = 21,
	parameter int MAX_FRAC_DIGITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] numerator,
	input  logic [30:0] denominator,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  digit,
	output logic        is_fraction,
	output logic        last
);

	localparam int DEPTH = MAX_INT_DIGITS + MAX_FRAC_DIGITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NIW   = $clog2(MAX_INT_DIGITS + 1);
	localparam int NFW   = $clog2(MAX_FRAC_DIGITS + 1);
	localparam logic [AW-1:0] INT_BASE = AW'(MAX_INT_DIGITS);

	function automatic btfc_pkg::digit_t sign_swap(input btfc_pkg::digit_t d, input logic neg);
		btfc_pkg::digit_t r;
		r = d;
		if (neg && d != btfc_pkg::DIGIT_ZERO) begin
			r = 2'd3 - d;
		end
		return r;
	endfunction

	btfc_pkg::state_t state_q;
	logic             out_valid_q;
	logic             neg_q;
	logic [30:0]      b_q;
	logic [31:0]      dq_q;
	logic [30:0]      rem_q;
	logic [4:0]       div_cnt_q;
	logic [30:0]      quot3_q;
	logic [NIW-1:0]   ni_q;
	logic [NFW-1:0]   nf_q;
	logic             carry_q;
	logic [AW-1:0]    ptr_q;
	btfc_pkg::digit_t digit_q;
	logic             frac_q;
	logic             last_q;

	logic [1:0]       mem [DEPTH];
	logic [1:0]       mem_rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [1:0]       mem_wd;

	logic             accept_in;
	logic             accept_out;
	logic [31:0]      mag;
	logic [32:0]      div_diff;
	logic [31:0]      div_shift;
	logic             div_ge;
	logic [63:0]      prod;
	logic [31:0]      three_quot;
	logic [31:0]      int_rem;
	logic [32:0]      r3;
	logic [32:0]      b1_ext;
	logic [32:0]      b2_ext;
	logic             ge1;
	logic             ge2;
	logic [32:0]      r3_next;
	logic [1:0]       frac_digit;
	logic             int_done;
	logic             frac_done;
	logic [2:0]       carry_sum;
	logic             carry_out;
	logic [1:0]       carry_digit;
	logic [AW-1:0]    start_addr;
	logic [AW-1:0]    end_addr;
	logic             no_digits;
	btfc_pkg::digit_t plain_digit;

	assign accept_in  = in_valid && in_ready;
	assign accept_out = out_valid_q && out_ready;
	assign in_ready   = (state_q == btfc_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign digit      = digit_q;
	assign is_fraction = frac_q;
	assign last       = last_q;

	assign mag = numerator[31] ? (~numerator + 32'd1) : numerator;

	// Restoring division step: one quotient bit per cycle.
	assign div_shift = {rem_q, dq_q[31]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, b_q};
	assign div_ge    = !div_diff[32];

	// Integer digit: quotient by three through the reciprocal, remainder next cycle.
	assign prod       = {32'd0, dq_q} * {32'd0, btfc_pkg::RECIP3};
	assign three_quot = {quot3_q, 1'b0} + {1'b0, quot3_q};
	assign int_rem    = dq_q - three_quot;
	assign int_done   = (dq_q == 32'd0) || (ni_q == NIW'(MAX_INT_DIGITS));

	// Fraction digit: 3r compared against b and 2b.
	assign r3      = {2'b00, rem_q} + {1'b0, rem_q, 1'b0};
	assign b1_ext  = {2'b00, b_q};
	assign b2_ext  = {1'b0, b_q, 1'b0};
	assign ge2     = (r3 >= b2_ext);
	assign ge1     = (r3 >= b1_ext);
	assign r3_next = ge2 ? (r3 - b2_ext) : (ge1 ? (r3 - b1_ext) : r3);
	assign frac_digit = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
	assign frac_done  = (rem_q == 31'd0) || (nf_q == NFW'(MAX_FRAC_DIGITS));

	// Add-one-with-carry pass, least significant digit first.
	assign carry_sum   = {1'b0, mem_rd_q} + 3'd1 + {2'b00, carry_q};
	assign carry_out   = (carry_sum >= 3'd3);
	assign carry_digit = carry_out ? 2'(carry_sum - 3'd3) : carry_sum[1:0];

	assign start_addr = INT_BASE - AW'(ni_q);
	assign end_addr   = INT_BASE + AW'(nf_q) - AW'(1);
	assign no_digits  = (ni_q == '0) && (nf_q == '0);

	// Subtract one without borrow: (d + 2) mod 3.
	assign plain_digit = (mem_rd_q == 2'd0) ? btfc_pkg::DIGIT_MINUS :
		((mem_rd_q == 2'd1) ? btfc_pkg::DIGIT_ZERO : btfc_pkg::DIGIT_PLUS);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = carry_digit;
		unique case (state_q)
			btfc_pkg::ST_INT_SUB: begin
				mem_we = 1'b1;
				mem_wa = INT_BASE - AW'(1) - AW'(ni_q);
				mem_wd = int_rem[1:0];
			end
			btfc_pkg::ST_FRAC: begin
				mem_we = !frac_done;
				mem_wa = INT_BASE + AW'(nf_q);
				mem_wd = frac_digit;
			end
			btfc_pkg::ST_CARRY_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btfc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				btfc_pkg::ST_IDLE: begin
					if (accept_in) begin
						state_q <= (denominator == 31'd0) ? btfc_pkg::ST_HEAD : btfc_pkg::ST_DIV;
					end
				end
				btfc_pkg::ST_DIV: begin
					if (div_cnt_q == 5'd31) begin
						state_q <= btfc_pkg::ST_INT_MUL;
					end
				end
				btfc_pkg::ST_INT_MUL: begin
					state_q <= int_done ? btfc_pkg::ST_FRAC : btfc_pkg::ST_INT_SUB;
				end
				btfc_pkg::ST_INT_SUB: begin
					state_q <= btfc_pkg::ST_INT_MUL;
				end
				btfc_pkg::ST_FRAC: begin
					if (frac_done) begin
						state_q <= no_digits ? btfc_pkg::ST_HEAD : btfc_pkg::ST_CARRY_RD;
					end
				end
				btfc_pkg::ST_CARRY_RD: begin
					state_q <= btfc_pkg::ST_CARRY_WR;
				end
				btfc_pkg::ST_CARRY_WR: begin
					state_q <= (ptr_q == start_addr) ? btfc_pkg::ST_HEAD : btfc_pkg::ST_CARRY_RD;
				end
				btfc_pkg::ST_HEAD: begin
					if (carry_q || ni_q == '0) begin
						state_q     <= btfc_pkg::ST_SEND;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= btfc_pkg::ST_EMIT_RD;
					end
				end
				btfc_pkg::ST_EMIT_RD: begin
					state_q <= btfc_pkg::ST_EMIT_LD;
				end
				btfc_pkg::ST_EMIT_LD: begin
					state_q     <= btfc_pkg::ST_SEND;
					out_valid_q <= 1'b1;
				end
				btfc_pkg::ST_SEND: begin
					if (accept_out) begin
						out_valid_q <= 1'b0;
						state_q     <= last_q ? btfc_pkg::ST_IDLE : btfc_pkg::ST_EMIT_RD;
					end
				end
				default: begin
					state_q     <= btfc_pkg::ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			btfc_pkg::ST_IDLE: begin
				neg_q     <= numerator[31];
				b_q       <= denominator;
				dq_q      <= mag;
				rem_q     <= 31'd0;
				div_cnt_q <= 5'd0;
				ni_q      <= '0;
				nf_q      <= '0;
				carry_q   <= 1'b0;
			end
			btfc_pkg::ST_DIV: begin
				dq_q      <= {dq_q[30:0], div_ge};
				rem_q     <= div_ge ? div_diff[30:0] : div_shift[30:0];
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			btfc_pkg::ST_INT_MUL: begin
				quot3_q <= prod[63:33];
			end
			btfc_pkg::ST_INT_SUB: begin
				dq_q <= {1'b0, quot3_q};
				ni_q <= ni_q + NIW'(1);
			end
			btfc_pkg::ST_FRAC: begin
				if (frac_done) begin
					ptr_q <= end_addr;
				end else begin
					rem_q <= r3_next[30:0];
					nf_q  <= nf_q + NFW'(1);
				end
			end
			btfc_pkg::ST_CARRY_WR: begin
				carry_q <= carry_out;
				if (ptr_q != start_addr) begin
					ptr_q <= ptr_q - AW'(1);
				end
			end
			btfc_pkg::ST_HEAD: begin
				ptr_q   <= start_addr;
				frac_q  <= 1'b0;
				last_q  <= no_digits;
				digit_q <= carry_q ? sign_swap(btfc_pkg::DIGIT_PLUS, neg_q) : btfc_pkg::DIGIT_ZERO;
			end
			btfc_pkg::ST_EMIT_LD: begin
				digit_q <= sign_swap(plain_digit, neg_q);
				frac_q  <= (ptr_q >= INT_BASE);
				last_q  <= (ptr_q == end_addr);
				ptr_q   <= ptr_q + AW'(1);
			end
			default: begin
				carry_q <= carry_q;
			end
		endcase
	end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the balanced ternary fraction converter.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_INT_DIGITS  = 21;
	localparam int MAX_FRAC_DIGITS = 20;
	localparam int RANDOM_NUMBERS  = 420;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int DRAIN_CYCLES    = 400;
	localparam int N_DIRECTED      = 23;

	typedef struct packed {
		btfc_pkg::digit_t digit;
		logic             is_fraction;
		logic             last;
	} digit_rec_t;

	// A typed row carries its single expected digit; other rows use the predictor.
	typedef struct packed {
		logic [31:0]      num;
		logic [30:0]      den;
		logic             typed;
		btfc_pkg::digit_t want;
	} number_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] numerator = '0;
	logic [30:0] denominator = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  digit;
	logic        is_fraction;
	logic        last;

	digit_rec_t  digits_due[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          steady = 1'b0;

	const number_row_t directed [N_DIRECTED] = '{
		'{32'd0,          31'd0 + 31'd1,   1'b1, btfc_pkg::DIGIT_ZERO},
		'{32'd5,          31'd0,           1'b1, btfc_pkg::DIGIT_ZERO},
		'{32'h8000_0000,  31'd0,           1'b1, btfc_pkg::DIGIT_ZERO},
		'{32'h7FFF_FFFF,  31'd0,           1'b1, btfc_pkg::DIGIT_ZERO},
		'{32'd0,          31'd1162261467,  1'b1, btfc_pkg::DIGIT_ZERO},
		'{32'd1,          31'd1,           1'b1, btfc_pkg::DIGIT_PLUS},
		'{32'hFFFF_FFFF,  31'd1,           1'b1, btfc_pkg::DIGIT_MINUS},
		'{32'd2,          31'd1,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'hFFFF_FFFE,  31'd1,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'h7FFF_FFFF,  31'd1,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'h8000_0000,  31'd1,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'h8000_0000,  31'd3,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'h7FFF_FFFF,  31'd1162261467,  1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'd1,          31'd1162261467,  1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'hFFFF_FFFF,  31'd1162261467,  1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'd1,          31'd2,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'hFFFF_FFFF,  31'd7,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'd13,         31'd9,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'hFFFF_FFF3,  31'd9,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'd4,          31'd3,           1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'hFFFF_FFFB,  31'd27,          1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'd1162261466, 31'd1162261466,  1'b0, btfc_pkg::DIGIT_ZERO},
		'{32'h8000_0001,  31'd2,           1'b0, btfc_pkg::DIGIT_ZERO}
	};

	balanced_ternary_fraction_converter #(
		.MAX_INT_DIGITS (MAX_INT_DIGITS),
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.numerator  (numerator),
		.denominator(denominator),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit      (digit),
		.is_fraction(is_fraction),
		.last       (last)
	);

	always #5 clk = ~clk;

	function automatic btfc_pkg::digit_t signed_digit(input int unsigned d, input logic neg);
		if (!neg || d == 0) begin
			return btfc_pkg::digit_t'(d);
		end
		return btfc_pkg::digit_t'(3 - d);
	endfunction

	// Expands num / den into balanced ternary digits and queues them.
	function automatic void predict_digits(input logic [31:0] num, input logic [30:0] den);
		logic            neg;
		logic [31:0]     mag;
		longint unsigned q, r, b;
		int unsigned     int_rev [MAX_INT_DIGITS];
		int unsigned     trits [MAX_INT_DIGITS + MAX_FRAC_DIGITS];
		int unsigned     t, carry;
		int              ni, nf, cnt, i, head, total;
		digit_rec_t      rec;
		if (den == '0) begin
			digits_due.push_back('{btfc_pkg::DIGIT_ZERO, 1'b0, 1'b1});
			return;
		end
		neg = num[31];
		mag = neg ? -num : num;
		b = 64'(den);
		q = 64'(mag) / b;
		r = 64'(mag) % b;
		ni = 0;
		while (q != 0 && ni < MAX_INT_DIGITS) begin
			int_rev[ni] = int'(q % 3);
			q = q / 3;
			ni++;
		end
		for (i = 0; i < ni; i++)
			trits[i] = int_rev[ni - 1 - i];
		nf = 0;
		while (r != 0 && nf < MAX_FRAC_DIGITS) begin
			r = r * 3;
			trits[ni + nf] = int'(r / b);
			r = r % b;
			nf++;
		end
		cnt = ni + nf;
		// Add one everywhere with a rippling carry, then take one away with no borrow.
		carry = 0;
		for (i = cnt - 1; i >= 0; i--) begin
			t = trits[i] + 1 + carry;
			trits[i] = t % 3;
			carry = t / 3;
		end
		for (i = 0; i < cnt; i++)
			trits[i] = (trits[i] + 2) % 3;
		head = (carry != 0 || ni == 0) ? 1 : 0;
		total = head + cnt;
		if (head != 0) begin
			rec.digit = signed_digit(carry, neg);
			rec.is_fraction = 1'b0;
			rec.last = (total == 1);
			digits_due.push_back(rec);
		end
		for (i = 0; i < cnt; i++) begin
			rec.digit = signed_digit(trits[i], neg);
			rec.is_fraction = (i >= ni);
			rec.last = (head + i == total - 1);
			digits_due.push_back(rec);
		end
	endfunction

	function automatic logic [30:0] power_of_three(input int k);
		logic [30:0] p;
		p = 31'd1;
		for (int i = 0; i < k; i++)
			p = p * 31'd3;
		return p;
	endfunction

	function automatic logic [31:0] pick_numerator();
		logic [31:0] v;
		case ($urandom_range(0, 11))
			0: v = 32'd0;
			1: v = 32'h8000_0000;
			2: v = 32'h7FFF_FFFF;
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [30:0] pick_denominator();
		logic [30:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1: v = 31'($urandom_range(1, 100));
			2, 3: v = 31'($urandom_range(1, 1162261467));
			default: v = power_of_three($urandom_range(0, 19));
		endcase
		return v;
	endfunction

	// Holds the transaction on the input until the converter takes it.
	task automatic send_number(input logic [31:0] num, input logic [30:0] den);
		in_valid <= 1'b1;
		numerator <= num;
		denominator <= den;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic maybe_pause();
		if (!steady && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 50);
		end
	endtask

	task automatic flag_mismatch(input string what, input digit_rec_t want,
			input digit_rec_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected digit %0d frac %0b last %0b, %s %0d frac %0b last %0b",
				$time, what, want.digit, want.is_fraction, want.last,
				"got digit", got.digit, got.is_fraction, got.last);
	endtask

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 16);
	end

	always @(posedge clk) begin : check_digits
		digit_rec_t want;
		digit_rec_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = '{digit, is_fraction, last};
			if (digits_due.size() == 0) begin
				flag_mismatch("digit with nothing outstanding", '0, got);
			end else begin
				want = digits_due.pop_front();
				if (got !== want)
					flag_mismatch("digit mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d digits outstanding", digits_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		number_row_t row;
		logic [31:0] num;
		logic [30:0] den;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIRECTED; k++) begin
			row = directed[k];
			send_number(row.num, row.den);
			if (row.typed)
				digits_due.push_back('{row.want, 1'b0, 1'b1});
			else
				predict_digits(row.num, row.den);
			maybe_pause();
		end

		for (int k = 0; k < RANDOM_NUMBERS; k++) begin
			// A stretch in the middle runs with no idling on either side.
			steady = (k >= 180 && k < 280);
			num = pick_numerator();
			den = pick_denominator();
			send_number(num, den);
			predict_digits(num, den);
			maybe_pause();
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (digits_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: balanced_ternary_fraction_converter.f
rtl/btfc_pkg.sv
rtl/balanced_ternary_fraction_converter.sv
tb/testbench.sv
